### sv/frsp_pkg.sv
// Package for the FIT record stream parser.
// Holds the phase and record-state types, event codes, result struct and the
// nibble-table CRC-16 step. No dependencies.
package frsp_pkg;

    // File-level phase.
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DATA   = 2'd1,
        PH_DCRC   = 2'd2,
        PH_IDLE   = 2'd3
    } t_phase;

    // Record-level state inside the data section.
    typedef enum logic [1:0] {
        RS_HDR    = 2'd0,
        RS_DEFFIX = 2'd1,
        RS_DEFFLD = 2'd2,
        RS_DATA   = 2'd3
    } t_rec_state;

    // Event codes reported on the result stream.
    typedef enum logic [2:0] {
        EV_HDR_OK    = 3'd0,
        EV_HDR_BAD   = 3'd1,
        EV_TIME      = 3'd2,
        EV_SPEED     = 3'd3,
        EV_FILE_OK   = 3'd4,
        EV_FILE_BAD  = 3'd5,
        EV_TOO_MANY  = 3'd6,
        EV_RESERVED  = 3'd7
    } t_event;

    // Configuration register indexes.
    localparam logic [1:0] REG_SPEED_MSG   = 2'd0;
    localparam logic [1:0] REG_SPEED_FIELD = 2'd1;
    localparam logic [1:0] REG_TIME_FIELD  = 2'd2;

    localparam logic [15:0] SPEED_MSG_RESET   = 16'd19;
    localparam logic [7:0]  SPEED_FIELD_RESET = 8'd13;
    localparam logic [7:0]  TIME_FIELD_RESET  = 8'd4;
    localparam logic [7:0]  MIN_HEADER_LEN    = 8'd10;
    localparam int          LOCAL_TYPES       = 16;

    // One result transaction.
    typedef struct packed {
        t_event      ev;
        logic [31:0] value;
    } t_result;

    // CRC-16 (poly 0xA001) nibble table.
    function automatic logic [15:0] nib_tab(input logic [3:0] idx);
        logic [15:0] r;
        begin
            case (idx)
                4'h0: r = 16'h0000;
                4'h1: r = 16'hCC01;
                4'h2: r = 16'hD801;
                4'h3: r = 16'h1400;
                4'h4: r = 16'hF001;
                4'h5: r = 16'h3C00;
                4'h6: r = 16'h2800;
                4'h7: r = 16'hE401;
                4'h8: r = 16'hA001;
                4'h9: r = 16'h6C00;
                4'hA: r = 16'h7800;
                4'hB: r = 16'hB401;
                4'hC: r = 16'h5000;
                4'hD: r = 16'h9C01;
                4'hE: r = 16'h8801;
                default: r = 16'h4400;
            endcase
            return r;
        end
    endfunction

    // One byte of CRC, low nibble first.
    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] t;
        begin
            t = ((c >> 4) & 16'h0FFF) ^ nib_tab(c[3:0]) ^ nib_tab(b[3:0]);
            t = ((t >> 4) & 16'h0FFF) ^ nib_tab(t[3:0]) ^ nib_tab(b[7:4]);
            return t;
        end
    endfunction

endpackage

### sv/frsp_field_mem.sv
// Field descriptor memory: one entry {field number, size} per local type and slot.
// Synchronous write, registered read. Depends on nothing.
module frsp_field_mem #(
    parameter int AW = 9
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [15:0]   o_rdata
);
    logic [15:0] mem [(1 << AW)];
    logic [15:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### sv/frsp_out_buf.sv
// Two-entry result buffer between the parser and the master stream.
// Depends on frsp_pkg.
module frsp_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  frsp_pkg::t_result i_item,
    output logic             o_ready,
    output logic             o_valid,
    output frsp_pkg::t_result o_item,
    input  logic             i_pop_ready
);
    import frsp_pkg::*;

    t_result    r_q0, r_q1, n_q0, n_q1;
    logic [1:0] r_cnt, n_cnt;
    logic       pop;

    assign pop     = (r_cnt != 2'd0) && i_pop_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q0;
    assign o_ready = (r_cnt != 2'd2);

    // Queue update for push and pop.
    always_comb begin
        n_q0  = r_q0;
        n_q1  = r_q1;
        n_cnt = r_cnt;
        if (pop) begin
            n_q0  = r_q1;
            n_cnt = n_cnt - 2'd1;
        end
        if (i_push) begin
            if (n_cnt == 2'd0) begin
                n_q0 = i_item;
            end else begin
                n_q1 = i_item;
            end
            n_cnt = n_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("result buffer count out of range");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !i_pop_ready) |-> !i_push)
        else $error("push into full result buffer");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_pop_ready) |=> $stable(o_item))
        else $error("head result changed while stalled");
`endif
endmodule

### sv/fit_record_stream_parser.sv
// FIT record stream parser.
// Usage: one file byte per s_axis transaction, tdata[7:0] the byte and
// tuser[0] high on the first byte of a file, which restarts the parser
// (configuration registers are kept). The header is checked with CRC-16,
// definition records are stored per local type and data records are walked.
// Each byte yields zero or one result on m_axis: tuser[2:0] the event code
// (header ok/bad, time, speed, file ok/bad, too many fields), tdata the value.
// One byte is taken per cycle while the result buffer has room; a data byte's
// field descriptor is read from the field memory in the cycle before, when the
// previous byte picks the slot. The three registers lie on an APB port at byte
// addresses 0, 4 and 8; the user must write them only while the stream is
// idle, which the block does not enforce. Reset (synchronous, active low)
// returns the parser to waiting for a header; the field memory is not cleared,
// entries are only read through the per-type field counts. When m_axis stalls,
// two results are buffered; s_axis_tready falls only once both are waiting.
// Depends on frsp_pkg, frsp_field_mem and frsp_out_buf.
module fit_record_stream_parser #(
    parameter int MAX_FIELDS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] file_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] value
    output logic [2:0]  m_axis_tuser,   // [2:0] event_res
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import frsp_pkg::*;

    localparam int IW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
    localparam int AW = 4 + IW;

    // Configuration registers.
    logic [15:0] r_speed_msg;
    logic [7:0]  r_speed_field, r_time_field;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_msg   <= SPEED_MSG_RESET;
            r_speed_field <= SPEED_FIELD_RESET;
            r_time_field  <= TIME_FIELD_RESET;
        end else if (cfg_we) begin
            case (paddr[3:2])
                REG_SPEED_MSG:   r_speed_msg   <= pwdata[15:0];
                REG_SPEED_FIELD: r_speed_field <= pwdata[7:0];
                REG_TIME_FIELD:  r_time_field  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (paddr[3:2])
            REG_SPEED_MSG:   prdata = {16'd0, r_speed_msg};
            REG_SPEED_FIELD: prdata = {24'd0, r_speed_field};
            REG_TIME_FIELD:  prdata = {24'd0, r_time_field};
            default:         prdata = 32'd0;
        endcase
    end

    // Parser state.
    t_phase          r_phase, n_phase;
    t_rec_state      r_rs, n_rs;
    logic [31:0]     r_bcnt, n_bcnt;
    logic [7:0]      r_hlen, n_hlen;
    logic [31:0]     r_dlen, n_dlen;
    logic [15:0]     r_crc, n_crc;
    logic [15:0]     r_crc_rx, n_crc_rx;
    logic [3:0]      r_local, n_local;
    logic [15:0]     r_def_gmn, n_def_gmn;
    logic [7:0]      r_def_total, n_def_total;
    logic [2:0]      r_cursor, n_cursor;
    logic [7:0]      r_fi, n_fi;
    logic [1:0]      r_part, n_part;
    logic [7:0]      r_fnum, n_fnum;
    logic [IW-1:0]   r_fidx, n_fidx;
    logic [7:0]      r_fpos, n_fpos;
    logic [31:0]     r_fval, n_fval;
    logic            r_tpend, n_tpend;
    logic [AW-1:0]   r_slot, n_slot;

    // Per-type tables in flip-flops.
    logic [15:0]           r_gmn  [LOCAL_TYPES];
    logic [7:0]            r_fcnt [LOCAL_TYPES];
    logic [MAX_FIELDS-1:0] r_mask [LOCAL_TYPES];

    logic                  acc, restart;
    logic [7:0]            b;
    logic [15:0]           ent;
    logic                  ev_valid;
    t_event                ev;
    logic [31:0]           ev_value;
    logic                  buf_ready;

    // Table write requests.
    logic                  gmn_we, cnt_we, mask_we, mem_we;
    logic [7:0]            cnt_wdata;
    logic [AW-1:0]         mem_waddr;
    logic [15:0]           mem_wdata;

    // Field seek.
    logic                  seek;
    logic [3:0]            seek_local;
    logic [IW:0]           seek_start;
    logic                  seek_found;
    logic [IW-1:0]         seek_idx;
    logic [7:0]            seek_cnt;

    assign acc     = s_axis_tvalid && s_axis_tready;
    assign restart = s_axis_tuser;
    assign b       = s_axis_tdata;
    assign s_axis_tready = buf_ready;

    // Next stored field of nonzero size at or after the start index.
    always_comb begin
        seek_cnt   = r_fcnt[seek_local];
        seek_found = 1'b0;
        seek_idx   = '0;
        for (int j = MAX_FIELDS - 1; j >= 0; j--) begin
            if (r_mask[seek_local][j] && (j < int'(seek_cnt)) && (j >= int'(seek_start))) begin
                seek_found = 1'b1;
                seek_idx   = IW'(j);
            end
        end
    end

    // Byte processing.
    always_comb begin
        logic [7:0]  hl;
        logic [8:0]  pos1;
        logic [31:0] fv;
        logic [15:0] crc_new;

        n_phase     = r_phase;
        n_rs        = r_rs;
        n_bcnt      = r_bcnt;
        n_hlen      = r_hlen;
        n_dlen      = r_dlen;
        n_crc       = r_crc;
        n_crc_rx    = r_crc_rx;
        n_local     = r_local;
        n_def_gmn   = r_def_gmn;
        n_def_total = r_def_total;
        n_cursor    = r_cursor;
        n_fi        = r_fi;
        n_part      = r_part;
        n_fnum      = r_fnum;
        n_fidx      = r_fidx;
        n_fpos      = r_fpos;
        n_fval      = r_fval;
        n_tpend     = r_tpend;
        n_slot      = r_slot;

        gmn_we     = 1'b0;
        cnt_we     = 1'b0;
        cnt_wdata  = 8'd0;
        mask_we    = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = {r_local, r_fi[IW-1:0]};
        mem_wdata  = {r_fnum, b};
        seek       = 1'b0;
        seek_local = r_local;
        seek_start = '0;
        ev_valid   = 1'b0;
        ev         = EV_HDR_OK;
        ev_value   = 32'd0;
        hl         = 8'd0;
        pos1       = 9'd0;
        fv         = 32'd0;
        crc_new    = 16'd0;

        if (acc) begin
            // A file start clears the parser before the byte is handled.
            if (restart) begin
                n_phase     = PH_HEADER;
                n_rs        = RS_HDR;
                n_bcnt      = 32'd0;
                n_hlen      = 8'd0;
                n_dlen      = 32'd0;
                n_crc       = 16'd0;
                n_crc_rx    = 16'd0;
                n_local     = 4'd0;
                n_def_gmn   = 16'd0;
                n_def_total = 8'd0;
                n_cursor    = 3'd0;
                n_fi        = 8'd0;
                n_part      = 2'd0;
                n_fidx      = '0;
                n_fpos      = 8'd0;
                n_fval      = 32'd0;
                n_tpend     = 1'b1;
            end

            crc_new = crc_step(n_crc, b);

            case (n_phase)
                PH_HEADER: begin
                    hl = (n_bcnt == 32'd0) ? ((b < MIN_HEADER_LEN) ? MIN_HEADER_LEN : b)
                                           : n_hlen;
                    n_hlen = hl;
                    case (n_bcnt)
                        32'd4: n_dlen = {n_dlen[31:8], b};
                        32'd5: n_dlen = {n_dlen[31:16], b, n_dlen[7:0]};
                        32'd6: n_dlen = {n_dlen[31:24], b, n_dlen[15:0]};
                        32'd7: n_dlen = {b, n_dlen[23:0]};
                        default: ;
                    endcase
                    if (n_bcnt < {24'd0, hl - 8'd2}) begin
                        n_crc  = crc_new;
                        n_bcnt = n_bcnt + 32'd1;
                    end else if (n_bcnt == {24'd0, hl - 8'd2}) begin
                        n_crc_rx = {8'd0, b};
                        n_bcnt   = n_bcnt + 32'd1;
                    end else begin
                        ev_valid = 1'b1;
                        if ({b, n_crc_rx[7:0]} == n_crc) begin
                            ev      = EV_HDR_OK;
                            n_crc   = 16'd0;
                            n_rs    = RS_HDR;
                            n_phase = (n_dlen == 32'd0) ? PH_DCRC : PH_DATA;
                        end else begin
                            ev      = EV_HDR_BAD;
                            n_phase = PH_IDLE;
                        end
                        n_crc_rx = {b, n_crc_rx[7:0]};
                        n_bcnt   = 32'd0;
                    end
                end
                PH_DATA: begin
                    n_crc = crc_new;
                    case (n_rs)
                        RS_HDR: begin
                            n_local = b[3:0];
                            if (b[7:4] != 4'd0) begin
                                n_rs     = RS_DEFFIX;
                                n_cursor = 3'd0;
                            end else begin
                                seek       = 1'b1;
                                seek_local = b[3:0];
                                seek_start = '0;
                            end
                        end
                        RS_DEFFIX: begin
                            case (n_cursor)
                                3'd2: n_def_gmn = {8'd0, b};
                                3'd3: n_def_gmn = {b, n_def_gmn[7:0]};
                                default: ;
                            endcase
                            if (n_cursor == 3'd4) begin
                                gmn_we      = 1'b1;
                                cnt_we      = 1'b1;
                                cnt_wdata   = 8'd0;
                                n_def_total = b;
                                if (int'(b) > MAX_FIELDS) begin
                                    ev_valid = 1'b1;
                                    ev       = EV_TOO_MANY;
                                end
                                n_cursor = 3'd0;
                                n_fi     = 8'd0;
                                n_part   = 2'd0;
                                n_rs     = (b == 8'd0) ? RS_HDR : RS_DEFFLD;
                            end else begin
                                n_cursor = n_cursor + 3'd1;
                            end
                        end
                        RS_DEFFLD: begin
                            if (int'(n_fi) < MAX_FIELDS) begin
                                case (n_part)
                                    2'd0: n_fnum = b;
                                    2'd1: begin
                                        mem_we  = 1'b1;
                                        mask_we = 1'b1;
                                    end
                                    default: begin
                                        cnt_we    = 1'b1;
                                        cnt_wdata = n_fi + 8'd1;
                                    end
                                endcase
                            end
                            if (n_part == 2'd2) begin
                                if (n_fi == n_def_total - 8'd1) begin
                                    n_rs = RS_HDR;
                                end
                                n_fi   = n_fi + 8'd1;
                                n_part = 2'd0;
                            end else begin
                                n_part = n_part + 2'd1;
                            end
                        end
                        default: begin
                            // Data field byte: ent is the descriptor of the current slot.
                            fv = n_fval;
                            if (n_fpos < 8'd4) begin
                                case (n_fpos[1:0])
                                    2'd0: fv[7:0]   = fv[7:0]   | b;
                                    2'd1: fv[15:8]  = fv[15:8]  | b;
                                    2'd2: fv[23:16] = fv[23:16] | b;
                                    default: fv[31:24] = fv[31:24] | b;
                                endcase
                            end
                            n_fval = fv;
                            pos1   = {1'b0, n_fpos} + 9'd1;
                            n_fpos = pos1[7:0];
                            if (pos1 >= {1'b0, ent[7:0]}) begin
                                if (n_tpend && ent[15:8] == r_time_field) begin
                                    n_tpend  = 1'b0;
                                    ev_valid = 1'b1;
                                    ev       = EV_TIME;
                                    ev_value = fv;
                                end else if (r_gmn[n_local] == r_speed_msg &&
                                             ent[15:8] == r_speed_field) begin
                                    ev_valid = 1'b1;
                                    ev       = EV_SPEED;
                                    ev_value = {16'd0, fv[15:0]};
                                end
                                seek       = 1'b1;
                                seek_local = n_local;
                                seek_start = {1'b0, n_fidx} + (IW+1)'(1);
                            end
                        end
                    endcase
                    n_bcnt = n_bcnt + 32'd1;
                    if (n_bcnt >= n_dlen) begin
                        n_phase = PH_DCRC;
                        n_bcnt  = 32'd0;
                    end
                end
                PH_DCRC: begin
                    if (n_bcnt == 32'd0) begin
                        n_crc_rx = {8'd0, b};
                        n_bcnt   = 32'd1;
                    end else begin
                        n_crc_rx = {b, n_crc_rx[7:0]};
                        ev_valid = 1'b1;
                        ev       = ({b, n_crc_rx[7:0]} == n_crc) ? EV_FILE_OK : EV_FILE_BAD;
                        n_phase  = PH_IDLE;
                        n_bcnt   = 32'd0;
                    end
                end
                default: ;
            endcase

            // Start a field walk at the found slot, or end the record.
            if (seek) begin
                if (seek_found) begin
                    n_rs   = RS_DATA;
                    n_fidx = seek_idx;
                    n_fpos = 8'd0;
                    n_fval = 32'd0;
                    n_slot = {seek_local, seek_idx};
                end else begin
                    n_rs = RS_HDR;
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_rs        <= RS_HDR;
            r_bcnt      <= 32'd0;
            r_hlen      <= 8'd0;
            r_dlen      <= 32'd0;
            r_crc       <= 16'd0;
            r_crc_rx    <= 16'd0;
            r_local     <= 4'd0;
            r_def_gmn   <= 16'd0;
            r_def_total <= 8'd0;
            r_cursor    <= 3'd0;
            r_fi        <= 8'd0;
            r_part      <= 2'd0;
            r_fidx      <= '0;
            r_fpos      <= 8'd0;
            r_fval      <= 32'd0;
            r_tpend     <= 1'b1;
            r_slot      <= '0;
        end else begin
            r_phase     <= n_phase;
            r_rs        <= n_rs;
            r_bcnt      <= n_bcnt;
            r_hlen      <= n_hlen;
            r_dlen      <= n_dlen;
            r_crc       <= n_crc;
            r_crc_rx    <= n_crc_rx;
            r_local     <= n_local;
            r_def_gmn   <= n_def_gmn;
            r_def_total <= n_def_total;
            r_cursor    <= n_cursor;
            r_fi        <= n_fi;
            r_part      <= n_part;
            r_fidx      <= n_fidx;
            r_fpos      <= n_fpos;
            r_fval      <= n_fval;
            r_tpend     <= n_tpend;
            r_slot      <= n_slot;
        end
    end

    // Field number latch for the descriptor being defined.
    always_ff @(posedge i_clk) begin
        r_fnum <= n_fnum;
    end

    // Per-type tables: cleared at reset and file start, written by definitions.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (acc && restart)) begin
            for (int t = 0; t < LOCAL_TYPES; t++) begin
                r_gmn[t]  <= 16'd0;
                r_fcnt[t] <= 8'd0;
                r_mask[t] <= '0;
            end
        end else begin
            if (gmn_we) begin
                r_gmn[n_local] <= n_def_gmn;
            end
            if (cnt_we) begin
                r_fcnt[n_local] <= cnt_wdata;
            end
            if (mask_we) begin
                r_mask[n_local][r_fi[IW-1:0]] <= (b != 8'd0);
            end
        end
    end

    frsp_field_mem #(
        .AW (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (n_slot),
        .o_rdata (ent)
    );

    t_result res_in, res_out;

    assign res_in.ev    = ev;
    assign res_in.value = ev_value;

    frsp_out_buf u_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (acc && ev_valid),
        .i_item      (res_in),
        .o_ready     (buf_ready),
        .o_valid     (m_axis_tvalid),
        .o_item      (res_out),
        .i_pop_ready (m_axis_tready)
    );

    assign m_axis_tuser = res_out.ev;
    assign m_axis_tdata = res_out.value;

`ifndef SYNTHESIS
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != EV_TIME && m_axis_tuser != EV_SPEED)
        |-> (m_axis_tdata == 32'd0)) else $error("nonzero value on a verdict event");
    a_speed_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == EV_SPEED) |-> (m_axis_tdata[31:16] == 16'd0))
        else $error("speed value wider than 16 bits");
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid) else $error("input stalled with no result waiting");
    a_time_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !restart && !r_tpend) |-> !(ev_valid && ev == EV_TIME))
        else $error("second time event in one file");
`endif
endmodule

### sim/fit_record_stream_parser_test.sv
// Self-checking bench for fit_record_stream_parser: builds FIT-style files,
// predicts each byte's event in a behavioral model and checks m_axis results.
// Depends on frsp_pkg and the parser RTL.
module fit_record_stream_parser_test;
    timeunit 1ns;
    timeprecision 1ps;
    import frsp_pkg::*;

    localparam int NFLD = 32;
    localparam longint CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 0;
    logic        s_axis_tuser = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [3:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;

    fit_record_stream_parser dut (.*);

    // Clock generation.
    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // Bytes waiting to be sent, and results waiting to arrive.
    typedef struct packed {
        logic       start;
        logic [7:0] b;
    } t_byte_item;
    t_byte_item pending_bytes[$];
    t_result    expected_events[$];

    int  mismatches = 0;
    longint cycles = 0;
    bit  quiet = 0;          // no random idling
    bit  hold_sink = 0;      // long receiver stall
    bit  hold_req = 0;       // asks for one long receiver stall
    int  hold_left = 0;

    // Predictor state.
    logic [15:0] cfg_msg = SPEED_MSG_RESET;
    logic [7:0]  cfg_spd = SPEED_FIELD_RESET, cfg_tim = TIME_FIELD_RESET;
    t_phase      m_phase;
    t_rec_state  m_rs;
    logic [31:0] m_cnt, m_dlen, m_cursor, m_fval, m_total, m_fidx, m_fpos;
    logic [7:0]  m_hlen;
    logic [15:0] m_crc, m_rcrc, m_gmn_pend;
    logic [15:0] m_gmn[16];
    logic [7:0]  m_fcnt[16];
    logic [15:0] m_tab[16*NFLD];
    logic [3:0]  m_loc;
    bit          m_time_pend;

    function automatic logic [15:0] crc_nib(input logic [3:0] i);
        logic [15:0] r;
        r = 16'h0000;
        if (i[0]) r ^= 16'hCC01;
        if (i[1]) r ^= 16'hD801;
        if (i[2]) r ^= 16'hF001;
        if (i[3]) r ^= 16'hA001;
        return r;
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        c = ((c >> 4) & 16'h0FFF) ^ crc_nib(c[3:0]) ^ crc_nib(b[3:0]);
        c = ((c >> 4) & 16'h0FFF) ^ crc_nib(c[3:0]) ^ crc_nib(b[7:4]);
        return c;
    endfunction

    // Adds one byte at the tail of a byte queue.
    function automatic void append_byte(ref logic [7:0] q[$], input logic [7:0] v);
        q.insert(q.size(), v);
    endfunction

    task automatic parser_restart();
        m_phase = PH_HEADER; m_rs = RS_HDR;
        m_cnt = 0; m_dlen = 0; m_hlen = 0; m_crc = 0; m_rcrc = 0;
        m_cursor = 0; m_fval = 0; m_total = 0; m_fidx = 0; m_fpos = 0;
        m_gmn_pend = 0; m_loc = 0; m_time_pend = 1;
        for (int i = 0; i < 16; i++) begin
            m_gmn[i] = 0;
            m_fcnt[i] = 0;
        end
        for (int i = 0; i < 16*NFLD; i++) m_tab[i] = 0;
    endtask

    // Move to the next stored field of nonzero size, or end the record.
    task automatic next_field();
        while (m_fidx < m_fcnt[m_loc] && m_tab[m_loc*NFLD+m_fidx][7:0] == 0)
            m_fidx++;
        if (m_fidx < m_fcnt[m_loc]) begin
            m_rs = RS_DATA; m_fpos = 0; m_fval = 0;
        end else begin
            m_rs = RS_HDR;
        end
    endtask

    // Record-level parse of one data byte.
    task automatic parse_record_byte(input logic [7:0] b, inout int ev,
                                     inout logic [31:0] val);
        logic [15:0] ent;
        int fi, part;
        case (m_rs)
            RS_HDR: begin
                m_loc = b[3:0];
                if (b[7:4] != 0) begin
                    m_rs = RS_DEFFIX; m_cursor = 0;
                end else begin
                    m_fidx = 0; next_field();
                end
            end
            RS_DEFFIX: begin
                if (m_cursor == 4) begin
                    m_gmn[m_loc] = m_gmn_pend;
                    m_fcnt[m_loc] = 0;
                    m_total = {24'h0, b};
                    if (m_total > NFLD) ev = EV_TOO_MANY;
                    m_cursor = 0;
                    m_rs = (m_total == 0) ? RS_HDR : RS_DEFFLD;
                end else begin
                    if (m_cursor == 2) m_gmn_pend = {8'h00, b};
                    if (m_cursor == 3) m_gmn_pend[15:8] = b;
                    m_cursor++;
                end
            end
            RS_DEFFLD: begin
                fi = m_cursor / 3; part = m_cursor % 3;
                if (fi < NFLD) begin
                    if (part == 0) m_tab[m_loc*NFLD+fi] = {b, 8'h00};
                    else if (part == 1) m_tab[m_loc*NFLD+fi][7:0] = b;
                    else m_fcnt[m_loc] = 8'(fi + 1);
                end
                m_cursor++;
                if (m_cursor >= m_total * 3) m_rs = RS_HDR;
            end
            default: begin
                ent = m_tab[m_loc*NFLD+m_fidx];
                if (m_fpos < 4) m_fval |= 32'(b) << (8 * m_fpos);
                m_fpos++;
                if (m_fpos >= ent[7:0]) begin
                    if (m_time_pend && ent[15:8] == cfg_tim) begin
                        m_time_pend = 0; ev = EV_TIME; val = m_fval;
                    end else if (m_gmn[m_loc] == cfg_msg && ent[15:8] == cfg_spd) begin
                        ev = EV_SPEED; val = {16'h0, m_fval[15:0]};
                    end
                    m_fidx++;
                    next_field();
                end
            end
        endcase
    endtask

    // File-level prediction for one accepted byte.
    task automatic predict_byte(input t_byte_item it);
        int ev;
        logic [31:0] val;
        t_result r;
        ev = -1; val = 0;
        if (it.start) parser_restart();
        case (m_phase)
            PH_HEADER: begin
                if (m_cnt == 0) m_hlen = (it.b < 10) ? 8'd10 : it.b;
                if (m_cnt >= 4 && m_cnt <= 7) m_dlen |= 32'(it.b) << (8 * (m_cnt - 4));
                if (m_cnt < m_hlen - 2) begin
                    m_crc = crc_byte(m_crc, it.b); m_cnt++;
                end else if (m_cnt == m_hlen - 2) begin
                    m_rcrc = {8'h00, it.b}; m_cnt++;
                end else begin
                    m_rcrc[15:8] = it.b;
                    if (m_rcrc == m_crc) begin
                        ev = EV_HDR_OK; m_crc = 0; m_rs = RS_HDR;
                        m_phase = (m_dlen == 0) ? PH_DCRC : PH_DATA;
                    end else begin
                        ev = EV_HDR_BAD; m_phase = PH_IDLE;
                    end
                    m_cnt = 0;
                end
            end
            PH_DATA: begin
                m_crc = crc_byte(m_crc, it.b);
                parse_record_byte(it.b, ev, val);
                m_cnt++;
                if (m_cnt >= m_dlen) begin
                    m_phase = PH_DCRC; m_cnt = 0;
                end
            end
            PH_DCRC: begin
                if (m_cnt == 0) begin
                    m_rcrc = {8'h00, it.b}; m_cnt = 1;
                end else begin
                    m_rcrc[15:8] = it.b;
                    ev = (m_rcrc == m_crc) ? EV_FILE_OK : EV_FILE_BAD;
                    m_phase = PH_IDLE; m_cnt = 0;
                end
            end
            default: ;
        endcase
        if (ev >= 0) begin
            r.ev = t_event'(ev[2:0]);
            r.value = val;
            expected_events.insert(expected_events.size(), r);
        end
    endtask

    // Driver: offers queued bytes, idling at random.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) predict_byte({s_axis_tuser, s_axis_tdata});
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_bytes.size() > 0 && (quiet || $urandom_range(99) >= 27)) begin
                    s_axis_tvalid <= 1;
                    {s_axis_tuser, s_axis_tdata} <= pending_bytes.pop_front();
                end else begin
                    s_axis_tvalid <= 0;
                end
            end
        end
    end

    // Monitor: takes results and compares them with the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_events.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result: event %0d value %h",
                                 m_axis_tuser, m_axis_tdata);
                end else begin
                    want = expected_events.pop_front();
                    if (want.ev != m_axis_tuser || want.value != m_axis_tdata) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected event %0d value %h, got %0d %h",
                                     want.ev, want.value, m_axis_tuser, m_axis_tdata);
                    end
                end
            end
            m_axis_tready <= !hold_sink && (quiet || $urandom_range(99) >= 27);
        end
    end

    // Receiver hold-off: once requested, the sink stays stalled for a counted stretch.
    always @(posedge i_clk) begin
        if (hold_sink) begin
            hold_left <= hold_left - 1;
            if (hold_left <= 1) hold_sink <= 0;
        end else if (hold_req) begin
            hold_sink <= 1;
            hold_left <= HOLD_CYCLES;
        end
    end

    // Stimulus builders.
    task automatic push_byte(input logic [7:0] b, input bit start = 0);
        t_byte_item it;
        it.start = start; it.b = b;
        pending_bytes.insert(pending_bytes.size(), it);
    endtask

    // Appends a whole file; bad_hdr/bad_data corrupt a CRC, len_adj trims or pads the data.
    task automatic push_file(input logic [7:0] body[$], input int hlen,
                             input bit bad_hdr, input bit bad_data,
                             input int len_adj);
        logic [7:0] hdr[$];
        logic [15:0] c;
        int dlen;
        dlen = body.size() + len_adj;
        if (dlen < 0) dlen = 0;
        append_byte(hdr, hlen[7:0]);
        append_byte(hdr, 8'h10); append_byte(hdr, 8'h08); append_byte(hdr, 8'h00);
        append_byte(hdr, dlen[7:0]); append_byte(hdr, dlen[15:8]);
        append_byte(hdr, 8'h00); append_byte(hdr, 8'h00);
        while (hdr.size() < ((hlen < 10) ? 10 : hlen) - 2)
            append_byte(hdr, 8'($urandom_range(255)));
        c = 0;
        foreach (hdr[i]) c = crc_byte(c, hdr[i]);
        if (bad_hdr) c ^= 16'h0100 << $urandom_range(7);
        append_byte(hdr, c[7:0]); append_byte(hdr, c[15:8]);
        foreach (hdr[i]) push_byte(hdr[i], i == 0);
        c = 0;
        for (int i = 0; i < dlen; i++) begin
            logic [7:0] b;
            b = (i < body.size()) ? body[i] : 8'($urandom_range(255));
            c = crc_byte(c, b);
            push_byte(b);
        end
        if (bad_data) c ^= 16'h0001 << $urandom_range(15);
        push_byte(c[7:0]); push_byte(c[15:8]);
    endtask

    // Random body: definition and data records, each type defined before its data records.
    task automatic make_body(ref logic [7:0] body[$], input int nrec, input bit noisy);
        int nf[16];
        logic [7:0] sz[16][NFLD];
        bit defined[16];
        logic [7:0] nums[8];
        nums = '{cfg_tim, cfg_spd, 8'd0, 8'd253, 8'd255, cfg_spd, 8'd3, cfg_tim};
        foreach (defined[i]) defined[i] = 0;
        for (int r = 0; r < nrec; r++) begin
            int lt;
            lt = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(3);
            if (!defined[lt] || $urandom_range(3) == 0) begin
                int n;
                logic [15:0] g;
                n = ($urandom_range(19) == 0) ? $urandom_range(33, 40) : $urandom_range(0, 5);
                g = ($urandom_range(2) != 0) ? cfg_msg : 16'($urandom);
                append_byte(body, {4'($urandom_range(1, 15)), 4'(lt)});
                append_byte(body, 8'($urandom_range(255)));
                append_byte(body, 8'($urandom_range(1)));
                append_byte(body, g[7:0]); append_byte(body, g[15:8]);
                append_byte(body, n[7:0]);
                for (int f = 0; f < n; f++) begin
                    logic [7:0] s;
                    s = ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(1, 6));
                    if (f < NFLD) sz[lt][f] = s;
                    append_byte(body, nums[$urandom_range(7)]); append_byte(body, s);
                    append_byte(body, 8'($urandom_range(255)));
                end
                nf[lt] = (n > NFLD) ? NFLD : n;
                defined[lt] = 1;
            end else begin
                append_byte(body, {4'h0, 4'(lt)});
                for (int f = 0; f < nf[lt]; f++)
                    for (int k = 0; k < sz[lt][f]; k++)
                        append_byte(body, 8'($urandom_range(255)));
            end
            if (noisy && $urandom_range(9) == 0) append_byte(body, 8'($urandom_range(255)));
        end
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() > 0 || s_axis_tvalid || expected_events.size() > 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic set_regs(input logic [15:0] msg, input logic [7:0] spd,
                            input logic [7:0] tim);
        apb_write({REG_SPEED_MSG, 2'b00}, {16'h0, msg});
        apb_write({REG_SPEED_FIELD, 2'b00}, {24'h0, spd});
        apb_write({REG_TIME_FIELD, 2'b00}, {24'h0, tim});
        @(posedge i_clk);
        cfg_msg = msg; cfg_spd = spd; cfg_tim = tim;
    endtask

    // Watchdog.
    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stimulus sequence.
    initial begin
        logic [7:0] body[$];
        parser_restart();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: time and speed records under reset registers.
        body = '{8'h40, 8'h00, 8'h00, 8'd19, 8'd0, 8'd3,
                 8'd4, 8'd4, 8'h00, 8'd13, 8'd2, 8'h00, 8'd7, 8'd0, 8'h00,
                 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hAA, 8'h55,
                 8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h00, 8'h80};
        push_file(body, 14, 0, 0, 0);
        // Short header, empty data; bad header; bad data CRC; cut record.
        body.delete();
        push_file(body, 3, 0, 0, 0);
        push_file(body, 12, 1, 0, 0);
        push_byte(8'h00); push_byte(8'hFF);
        body = '{8'h41, 8'h00, 8'h00, 8'd19, 8'd0, 8'd1, 8'd13, 8'd4, 8'h00,
                 8'h01, 8'h12, 8'h34};
        push_file(body, 12, 0, 1, 0);
        push_file(body, 12, 0, 0, -1);
        push_byte(8'hFF, 1); push_byte(8'h00);
        wait_drained();

        // Random files over several register settings, extremes included.
        for (int phase_i = 0; phase_i < 4; phase_i++) begin
            case (phase_i)
                0: set_regs(16'hFFFF, 8'hFF, 8'h00);
                1: set_regs(16'h0000, 8'h00, 8'hFF);
                2: set_regs(16'($urandom), 8'd3, 8'd253);
                default: set_regs(SPEED_MSG_RESET, SPEED_FIELD_RESET, TIME_FIELD_RESET);
            endcase
            quiet = (phase_i == 1);
            for (int f = 0; f < 3; f++) begin
                body.delete();
                make_body(body, $urandom_range(1, 4), $urandom_range(4) == 0);
                push_file(body, $urandom_range(0, 16), $urandom_range(9) == 0,
                          $urandom_range(6) == 0,
                          ($urandom_range(5) == 0) ? -int'($urandom_range(1, 4)) : 0);
                if ($urandom_range(3) == 0) push_byte(8'($urandom_range(255)));
            end
            if (phase_i == 2) begin
                // Hold the receiver off while the sender keeps offering bytes.
                hold_req = 1;
                wait (hold_sink);
                hold_req = 0;
                wait (!hold_sink);
            end
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_events.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
